// File: sv/http_chunked_body_decoder_core_defines.svh
// Assertion macros shared by the chunked body decoder RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define HCBD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hcbd check failed");

// Next-cycle implication, checked out of reset
`define HCBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hcbd check failed");

`endif

// File: sv/hcbd_pkg.sv
// Types and constants of the chunked body decoder.
// No dependencies; imported by the parser, the result register and the top level.
package hcbd_pkg;

  // Parser phase, one-hot
  typedef enum logic [7:0] {
    PH_SIZE     = 8'b0000_0001,
    PH_SIZE_LF  = 8'b0000_0010,
    PH_DATA     = 8'b0000_0100,
    PH_END_CR   = 8'b0000_1000,
    PH_FINAL_CR = 8'b0001_0000,
    PH_END_LF   = 8'b0010_0000,
    PH_FINAL_LF = 8'b0100_0000,
    PH_FAILED   = 8'b1000_0000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_BAD_CHAR = 2'd0,
    ERR_NO_LF    = 2'd1,
    ERR_BAD_END  = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_e;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // One result item plus its valid flag
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] payload;
    err_e       code;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  // Decode one ASCII hex digit, either case
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.value = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: sv/hcbd_in_reg.sv
// Input register of the chunked body decoder: holds one raw byte.
// Depends on nothing but the handshake from the top level.
module hcbd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // Take a new item when empty or when the held one moves on
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on acceptance
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// File: sv/hcbd_parser.sv
// Chunked body parser: phase and remaining-byte counter, one byte per step.
// Depends on hcbd_pkg and the assertion macros header.
`include "http_chunked_body_decoder_core_defines.svh"

module hcbd_parser
  import hcbd_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output result_t    res_o
);

  localparam logic [COUNT_WIDTH-1:0] CountOne = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  hex_t                   hex;
  result_t                res;

  assign hex = hex_decode(byte_i);

  // Next phase, counter and result for the current byte
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    res.valid   = 1'b0;
    res.kind    = KIND_DATA;
    res.payload = 8'd0;
    res.code    = ERR_BAD_CHAR;
    if (step_i) begin
      case (phase_q)
        PH_SIZE: begin
          if (hex.ok) begin
            if (|count_q[COUNT_WIDTH-1 -: 4]) begin
              phase_d   = PH_FAILED;
              count_d   = '0;
              res.valid = 1'b1;
              res.kind  = KIND_ERROR;
              res.code  = ERR_OVERFLOW;
            end else begin
              count_d = {count_q[COUNT_WIDTH-5:0], hex.value};
            end
          end else if (byte_i == CHAR_CR) begin
            phase_d = PH_SIZE_LF;
          end else begin
            phase_d   = PH_FAILED;
            count_d   = '0;
            res.valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.code  = ERR_BAD_CHAR;
          end
        end
        PH_SIZE_LF: begin
          if (byte_i != CHAR_LF) begin
            phase_d   = PH_FAILED;
            count_d   = '0;
            res.valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.code  = ERR_NO_LF;
          end else if (count_q == '0) begin
            phase_d = PH_FINAL_CR;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          count_d     = count_q - CountOne;
          res.valid   = 1'b1;
          res.kind    = KIND_DATA;
          res.payload = byte_i;
          if (count_q == CountOne) begin
            phase_d = PH_END_CR;
          end
        end
        PH_END_CR, PH_FINAL_CR: begin
          if (byte_i != CHAR_CR) begin
            phase_d   = PH_FAILED;
            count_d   = '0;
            res.valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.code  = ERR_BAD_END;
          end else if (phase_q == PH_END_CR) begin
            phase_d = PH_END_LF;
          end else begin
            phase_d = PH_FINAL_LF;
          end
        end
        PH_END_LF, PH_FINAL_LF: begin
          if (byte_i != CHAR_LF) begin
            phase_d   = PH_FAILED;
            count_d   = '0;
            res.valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.code  = ERR_BAD_END;
          end else begin
            phase_d = PH_SIZE;
            count_d = '0;
            if (phase_q == PH_FINAL_LF) begin
              res.valid = 1'b1;
              res.kind  = KIND_END;
            end
          end
        end
        PH_FAILED: begin
          // drop every byte until reset
        end
        default: begin
          phase_d = PH_FAILED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  assign res_o = res;

  // Failure is sticky
  `HCBD_ASSERT_NEXT(a_failed_sticky, phase_q == PH_FAILED, phase_q == PH_FAILED)
  // An error result always lands in the failed phase
  `HCBD_ASSERT_NOW(a_error_fails, res.valid && res.kind == KIND_ERROR, phase_d == PH_FAILED)
  // Data phase never holds an empty counter
  `HCBD_ASSERT_NOW(a_data_nonzero, phase_q == PH_DATA, count_q != '0)
  // Final chunk trailer runs with a cleared counter
  `HCBD_ASSERT_NOW(a_final_zero, phase_q == PH_FINAL_CR || phase_q == PH_FINAL_LF,
                   count_q == '0)

endmodule

// File: sv/hcbd_out_reg.sv
// Result register of the chunked body decoder: holds one result item.
// Depends on hcbd_pkg for the result struct.
module hcbd_out_reg
  import hcbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  result_t    res_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] payload_byte_o,
  output logic [1:0] error_code_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Slot is free when empty or being drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i && res_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture a new result item
  always_ff @(posedge clk_i) begin
    if (free_o && load_i && res_i.valid) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign kind_o         = res_q.kind;
  assign payload_byte_o = res_q.payload;
  assign error_code_o   = res_q.code;

endmodule

// File: sv/http_chunked_body_decoder_core.sv
// Chunked HTTP/1.1 body decoder. Takes one raw byte per item and returns the
// body's payload bytes, an end-of-body item after the final zero-size chunk's
// CR LF, or one error item, after which bytes are dropped until reset. Sizes
// are hex, at most COUNT_WIDTH bits; extensions and trailers are not accepted.
// Throughput is one byte per clock while results are taken: a byte is held in
// the input register, passes the parser logic, and its result is loaded into
// the result register, from which the result item is offered. The pipe stalls
// only while a waiting result is not taken.
module http_chunked_body_decoder_core
  import hcbd_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] payload_byte_o,
  output logic [1:0] error_code_o
);

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       out_free;
  logic       advance;
  result_t    res;

  // Move the held byte through the parser when the result slot can take it
  assign advance = stage_valid && out_free;

  hcbd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .byte_o     (stage_byte)
  );

  hcbd_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (stage_byte),
    .res_o  (res)
  );

  hcbd_out_reg u_out_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (advance),
    .res_i          (res),
    .free_o         (out_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .error_code_o   (error_code_o)
  );

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for http_chunked_body_decoder_core.
// Drives a chunked byte stream and checks every result item against a predictor.
// Depends on hcbd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import hcbd_pkg::*;

  localparam int CNT_W = 32;
  localparam logic [7:0] CHAR_ZERO    = "0";
  localparam logic [7:0] CHAR_UPPER_A = "A";
  localparam logic [7:0] CHAR_LOWER_A = "a";
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    kind_e      kind;
    logic [7:0] payload;
    err_e       code;
  } dec_result_t;

  typedef enum int {
    TAIL_BAD_CHAR,
    TAIL_NO_LF,
    TAIL_BAD_END,
    TAIL_OVERFLOW,
    TAIL_HUGE
  } tail_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] payload_byte_o;
  logic [1:0] error_code_o;

  logic [7:0]  byte_q[$];
  dec_result_t decoded_q[$];

  // Predictor state
  phase_e           parse_phase = PH_SIZE;
  logic [CNT_W-1:0] size_count  = '0;

  int unsigned accepted_count = 0;
  int unsigned total_items    = 0;
  int unsigned mismatch_count = 0;
  int unsigned hold_left;
  bit          hold_done;

  http_chunked_body_decoder_core #(
    .COUNT_WIDTH(CNT_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .payload_byte_o(payload_byte_o),
    .error_code_o  (error_code_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Return 1 and the nibble value when c is an ASCII hex digit
  function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9") v = 4'(c - CHAR_ZERO);
    else if (c >= "a" && c <= "f") v = 4'(c - CHAR_LOWER_A + 10);
    else if (c >= "A" && c <= "F") v = 4'(c - CHAR_UPPER_A + 10);
    else return 1'b0;
    return 1'b1;
  endfunction

  // Advance the parser by one byte and queue the result it causes, if any
  function automatic void decode_byte(input logic [7:0] c);
    logic [3:0]  nib;
    bit          is_hex;
    bit          failed;
    err_e        err;
    dec_result_t r;
    is_hex    = hex_digit(c, nib);
    failed    = 1'b0;
    err       = ERR_BAD_CHAR;
    r.kind    = KIND_DATA;
    r.payload = 8'h00;
    r.code    = ERR_BAD_CHAR;
    case (parse_phase)
      PH_SIZE: begin
        if (is_hex) begin
          if (size_count[CNT_W-1 -: 4] != 4'd0) begin
            failed = 1'b1;
            err    = ERR_OVERFLOW;
          end else begin
            size_count = {size_count[CNT_W-5:0], nib};
          end
        end else if (c == CHAR_CR) begin
          parse_phase = PH_SIZE_LF;
        end else begin
          failed = 1'b1;
          err    = ERR_BAD_CHAR;
        end
      end
      PH_SIZE_LF: begin
        if (c != CHAR_LF) begin
          failed = 1'b1;
          err    = ERR_NO_LF;
        end else begin
          parse_phase = (size_count == '0) ? PH_FINAL_CR : PH_DATA;
        end
      end
      PH_DATA: begin
        size_count = size_count - 1'b1;
        if (size_count == '0) parse_phase = PH_END_CR;
        r.payload = c;
        decoded_q.push_back(r);
      end
      PH_END_CR, PH_FINAL_CR: begin
        if (c != CHAR_CR) begin
          failed = 1'b1;
          err    = ERR_BAD_END;
        end else begin
          parse_phase = (parse_phase == PH_END_CR) ? PH_END_LF : PH_FINAL_LF;
        end
      end
      PH_END_LF, PH_FINAL_LF: begin
        if (c != CHAR_LF) begin
          failed = 1'b1;
          err    = ERR_BAD_END;
        end else begin
          // The final chunk's closing CR LF ends the body
          if (parse_phase == PH_FINAL_LF) begin
            r.kind = KIND_END;
            decoded_q.push_back(r);
          end
          parse_phase = PH_SIZE;
          size_count  = '0;
        end
      end
      default: begin
      end
    endcase
    // Drop into the failed phase and report once
    if (failed) begin
      parse_phase = PH_FAILED;
      size_count  = '0;
      r.kind      = KIND_ERROR;
      r.code      = err;
      decoded_q.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Stream building
  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back(b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CHAR_ZERO + v;
    return ($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + v - 8'd10;
  endfunction

  function automatic logic [7:0] random_byte_except(input logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == avoid);
    return b;
  endfunction

  // Size line with random digit case and optional leading zeros
  task automatic push_size_line(input int unsigned n);
    int unsigned lead;
    bit          started;
    logic [3:0]  nib;
    lead    = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    started = 1'b0;
    repeat (lead) push_byte(CHAR_ZERO);
    for (int k = 7; k >= 0; k--) begin
      nib = 4'(n >> (4 * k));
      if (nib != 4'd0) started = 1'b1;
      if (started) push_byte(hex_char(nib));
    end
    if (n == 0 && lead == 0 && $urandom_range(3) != 0) push_byte(CHAR_ZERO);
    push_text("\r\n");
  endtask

  task automatic push_chunk(input int unsigned n);
    push_size_line(n);
    repeat (n) push_byte(8'($urandom_range(255)));
    push_text("\r\n");
  endtask

  task automatic push_body();
    int unsigned r;
    repeat ($urandom_range(1, 4)) begin
      r = $urandom_range(99);
      if (r < 80) push_chunk($urandom_range(1, 24));
      else if (r < 97) push_chunk($urandom_range(25, 80));
      else push_chunk($urandom_range(200, 300));
    end
    push_size_line(0);
    push_text("\r\n");
  endtask

  // Finish the stream with one malformed sequence, or a chunk too big to finish
  task automatic push_tail();
    tail_e      tail;
    logic [7:0] b;
    logic [3:0] nib;
    tail = tail_e'($urandom_range(4));
    case (tail)
      TAIL_BAD_CHAR: begin
        repeat ($urandom_range(2)) push_byte(hex_char(4'($urandom_range(15))));
        do b = 8'($urandom_range(255)); while (hex_digit(b, nib) || b == CHAR_CR);
        push_byte(b);
      end
      TAIL_NO_LF: begin
        push_size_line($urandom_range(1, 15));
        void'(byte_q.pop_back());
        push_byte(random_byte_except(CHAR_LF));
      end
      TAIL_BAD_END: begin
        case ($urandom_range(3))
          0: begin
            push_chunk($urandom_range(1, 8));
            repeat (2) void'(byte_q.pop_back());
            push_byte(random_byte_except(CHAR_CR));
          end
          1: begin
            push_chunk($urandom_range(1, 8));
            void'(byte_q.pop_back());
            push_byte(random_byte_except(CHAR_LF));
          end
          2: begin
            push_text("0\r\n");
            push_byte(random_byte_except(CHAR_CR));
          end
          default: begin
            push_text("0\r\n\r");
            push_byte(random_byte_except(CHAR_LF));
          end
        endcase
      end
      TAIL_OVERFLOW: begin
        // Leading zeros never overflow; the ninth significant digit does
        repeat ($urandom_range(3)) push_byte(CHAR_ZERO);
        push_byte(hex_char(4'($urandom_range(1, 15))));
        repeat (8) push_byte(hex_char(4'($urandom_range(15))));
      end
      default: begin
        repeat (8) push_byte(hex_char(4'hF));
        push_text("\r\n");
        repeat (30) push_byte(8'($urandom_range(255)));
      end
    endcase
    // Trailing bytes: dropped after an error, payload otherwise
    repeat (16) push_byte(8'($urandom_range(255)));
  endtask

  // Driver: present items from the pending stream, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned tx_pct;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= 8'h00;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_byte(in_byte_i);
        accepted_count++;
      end
      if (accepted_count < total_items / 3) tx_pct = 14;
      else if (accepted_count < 2 * total_items / 3) tx_pct = 85;
      else tx_pct = 0;
      if (!in_valid_i || in_ready_o) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= tx_pct) begin
          in_byte_i  <= byte_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_count >= 5 * total_items / 6) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    dec_result_t want;
    int unsigned rx_pct;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result, kind", kind_o, -1);
        end else begin
          want = decoded_q.pop_front();
          if (kind_o != want.kind) report_mismatch("kind", kind_o, want.kind);
          if (payload_byte_o != want.payload)
            report_mismatch("payload_byte", payload_byte_o, want.payload);
          if (error_code_o != want.code) report_mismatch("error_code", error_code_o, want.code);
        end
      end
      if (accepted_count < total_items / 3) rx_pct = 85;
      else if (accepted_count < 2 * total_items / 3) rx_pct = 14;
      else rx_pct = 0;
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= rx_pct);
    end
  end

  // Stimulus and end of run
  initial begin
    // Directed: leading zeros, payload extremes, CR inside data, empty size line
    push_text("01\r\n");
    push_byte(8'h00);
    push_text("\r\n2\r\n");
    push_byte(8'hFF);
    push_byte(CHAR_CR);
    push_text("\r\n\r\n\r\n");
    push_text("000\r\n\r\n");
    while (byte_q.size() < 1125) push_body();
    push_tail();
    total_items = byte_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (byte_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && decoded_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
